@@ rtl/core/mbrp_pkg.sv @@
// Shared types, codes and the CRC-16 step for the Modbus RTU response parser.
// Depends on nothing; every other file of the block uses it by scoped names.
package mbrp_pkg;

  // command codes on the request channel
  localparam logic [1:0] CMD_REQUEST = 2'd0;
  localparam logic [1:0] CMD_BYTE    = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_CRC_ERR     = 3'd1;
  localparam logic [2:0] ST_WRONG_SLAVE = 3'd2;
  localparam logic [2:0] ST_EXCEPTION   = 3'd3;
  localparam logic [2:0] ST_BAD_FUNC    = 3'd4;
  localparam logic [2:0] ST_TIMEOUT     = 3'd5;
  localparam logic [2:0] ST_BAD_LENGTH  = 3'd6;

  // configuration register indexes (paddr[2])
  localparam logic REG_UNIT_ID       = 1'b0;
  localparam logic REG_TIMEOUT_TICKS = 1'b1;

  localparam logic [7:0]  UNIT_ID_RESET = 8'h01;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [7:0]  FUNC_READ    = 8'h03;
  localparam int          FUNC_EXC_BIT = 7;
  localparam logic [15:0] TICK_MAX     = 16'hFFFF;

  localparam logic [8:0] LEN_EXCEPTION = 9'd5;
  localparam logic [8:0] LEN_OTHER     = 9'd7;
  localparam logic [8:0] LEN_READ_BASE = 9'd5;

  // widest store address over the legal range of the register count
  localparam int STORE_ADDR_MAX_W = 6;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] value;
    logic [6:0]  nregs;
  } fin_t;

  typedef struct packed {
    logic                        en;
    logic [STORE_ADDR_MAX_W-1:0] addr;
    logic [15:0]                 data;
  } wr_t;

  // one byte of the reflected CRC-16
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/core/mbrp_cfg.sv @@
// APB-style configuration registers: expected unit id and timeout.
// Depends on mbrp_pkg for register indexes and reset values.
module mbrp_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  unit_id,
  output logic [15:0] timeout_ticks
);

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_id       <= mbrp_pkg::UNIT_ID_RESET;
      timeout_ticks <= mbrp_pkg::TIMEOUT_RESET;
    end else if (wr_hit) begin
      case (paddr[2])
        mbrp_pkg::REG_UNIT_ID:       unit_id       <= pwdata[7:0];
        mbrp_pkg::REG_TIMEOUT_TICKS: timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      mbrp_pkg::REG_UNIT_ID:       prdata = {24'h000000, unit_id};
      mbrp_pkg::REG_TIMEOUT_TICKS: prdata = {16'h0000, timeout_ticks};
      default:                     prdata = 32'h00000000;
    endcase
  end

endmodule

@@ rtl/core/mbrp_frame.sv @@
// Frame tracker: byte position, running CRC, header bytes, tick counter and checks.
// Depends on mbrp_pkg; drives register writes into the store and finish requests.
module mbrp_frame #(
  parameter int MAX_REGS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [1:0]           cmd,
  input  logic [7:0]           rx_byte,
  input  logic [7:0]           unit_id,
  input  logic [15:0]          timeout_ticks,
  output logic                 fin_valid,
  output mbrp_pkg::fin_t       fin,
  output mbrp_pkg::wr_t        wr
);

  localparam logic [8:0] MAX_COUNT = 9'(2 * MAX_REGS);

  logic        waiting, waiting_next;
  logic [7:0]  pos, pos_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  crc_low, crc_low_next;
  logic [7:0]  addr_b, addr_b_next;
  logic [7:0]  func_b, func_b_next;
  logic [7:0]  count_b, count_b_next;
  logic [7:0]  hold, hold_next;
  logic [15:0] tick, tick_next;
  logic        fin_valid_next;
  mbrp_pkg::fin_t fin_next;

  logic [8:0]  pos9;
  logic [8:0]  len9;
  logic [7:0]  off;
  logic [15:0] rx_crc;

  assign pos9   = {1'b0, pos};
  assign off    = pos - 8'd3;
  assign rx_crc = {rx_byte, crc_low};

  always_comb begin
    if (func_b[mbrp_pkg::FUNC_EXC_BIT]) begin
      len9 = mbrp_pkg::LEN_EXCEPTION;
    end else if (func_b == mbrp_pkg::FUNC_READ) begin
      len9 = mbrp_pkg::LEN_READ_BASE + {1'b0, count_b};
    end else begin
      len9 = mbrp_pkg::LEN_OTHER;
    end
  end

  always_comb begin
    waiting_next   = waiting;
    pos_next       = pos;
    crc_next       = crc;
    crc_low_next   = crc_low;
    addr_b_next    = addr_b;
    func_b_next    = func_b;
    count_b_next   = count_b;
    hold_next      = hold;
    tick_next      = tick;
    fin_valid_next = 1'b0;
    fin_next       = '0;
    wr             = '0;
    if (accept) begin
      case (cmd)
        mbrp_pkg::CMD_REQUEST: begin
          waiting_next = 1'b1;
          pos_next     = 8'd0;
          crc_next     = mbrp_pkg::CRC_INIT;
          crc_low_next = 8'd0;
          addr_b_next  = 8'd0;
          func_b_next  = 8'd0;
          count_b_next = 8'd0;
          hold_next    = 8'd0;
          tick_next    = 16'd0;
        end
        mbrp_pkg::CMD_BYTE: begin
          if (waiting) begin
            pos_next = pos + 8'd1;
            if (pos == 8'd0) begin
              addr_b_next = rx_byte;
              crc_next    = mbrp_pkg::crc16_byte(crc, rx_byte);
            end else if (pos == 8'd1) begin
              func_b_next = rx_byte;
              crc_next    = mbrp_pkg::crc16_byte(crc, rx_byte);
            end else if (pos == 8'd2) begin
              count_b_next = rx_byte;
              crc_next     = mbrp_pkg::crc16_byte(crc, rx_byte);
              // for a read reply, an odd or oversized byte count ends the frame here, no CRC check
              if (func_b == mbrp_pkg::FUNC_READ &&
                  (rx_byte[0] || {1'b0, rx_byte} > MAX_COUNT)) begin
                waiting_next    = 1'b0;
                fin_valid_next  = 1'b1;
                fin_next.status = mbrp_pkg::ST_BAD_LENGTH;
              end
            end else if (pos9 + 9'd2 < len9) begin
              crc_next = mbrp_pkg::crc16_byte(crc, rx_byte);
              if (func_b == mbrp_pkg::FUNC_READ) begin
                if (!off[0]) begin
                  hold_next = rx_byte;
                end else begin
                  wr.en   = 1'b1;
                  wr.addr = off[mbrp_pkg::STORE_ADDR_MAX_W:1];
                  wr.data = {hold, rx_byte};
                end
              end
            end else if (pos9 + 9'd2 == len9) begin
              crc_low_next = rx_byte;
            end else begin
              waiting_next   = 1'b0;
              fin_valid_next = 1'b1;
              if (rx_crc != crc) begin
                fin_next.status = mbrp_pkg::ST_CRC_ERR;
              end else if (addr_b != unit_id) begin
                fin_next.status = mbrp_pkg::ST_WRONG_SLAVE;
              end else if (func_b[mbrp_pkg::FUNC_EXC_BIT]) begin
                fin_next.status = mbrp_pkg::ST_EXCEPTION;
                fin_next.value  = {8'h00, count_b};
              end else if (func_b != mbrp_pkg::FUNC_READ) begin
                fin_next.status = mbrp_pkg::ST_BAD_FUNC;
              end else begin
                fin_next.status = mbrp_pkg::ST_OK;
                fin_next.nregs  = count_b[7:1];
              end
            end
          end
        end
        mbrp_pkg::CMD_TICK: begin
          if (waiting) begin
            tick_next = (tick == mbrp_pkg::TICK_MAX) ? tick : tick + 16'd1;
            if (tick_next >= timeout_ticks) begin
              waiting_next    = 1'b0;
              fin_valid_next  = 1'b1;
              fin_next.status = mbrp_pkg::ST_TIMEOUT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting   <= 1'b0;
      pos       <= 8'd0;
      crc       <= mbrp_pkg::CRC_INIT;
      crc_low   <= 8'd0;
      addr_b    <= 8'd0;
      func_b    <= 8'd0;
      count_b   <= 8'd0;
      hold      <= 8'd0;
      tick      <= 16'd0;
      fin_valid <= 1'b0;
    end else begin
      waiting   <= waiting_next;
      pos       <= pos_next;
      crc       <= crc_next;
      crc_low   <= crc_low_next;
      addr_b    <= addr_b_next;
      func_b    <= func_b_next;
      count_b   <= count_b_next;
      hold      <= hold_next;
      tick      <= tick_next;
      fin_valid <= fin_valid_next;
    end
    fin <= fin_next;
  end

endmodule

@@ rtl/core/mbrp_emit.sv @@
// Register store memory and result sequencer: one status item or a register burst.
// Depends on mbrp_pkg; takes writes and finish requests from mbrp_frame.
module mbrp_emit #(
  parameter int MAX_REGS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  mbrp_pkg::wr_t  wr,
  input  logic           fin_valid,
  input  mbrp_pkg::fin_t fin,
  output logic           take_ok,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     status,
  output logic [4:0]     reg_index,
  output logic [15:0]    reg_value,
  output logic [5:0]     reg_count,
  output logic           last
);

  localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

  typedef enum logic [1:0] {
    E_IDLE,
    E_LOAD,
    E_HOLD
  } emit_state_t;

  emit_state_t state;
  logic [15:0] mem [MAX_REGS];
  logic [15:0] rd_data;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] idx;
  logic [6:0]  nregs;
  logic        burst_start;
  logic        single;
  logic        idx_last;

  assign burst_start = (state == E_IDLE) && fin_valid &&
                       fin.status == mbrp_pkg::ST_OK && fin.nregs != 7'd0;
  assign single      = (state == E_IDLE) && fin_valid && !burst_start;
  assign idx_last    = (7'(idx) + 7'd1) == nregs;

  // inputs are held off during a burst, so store writes and reads never overlap
  assign take_ok = (state == E_IDLE) && !fin_valid && (!out_valid || out_ready);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (burst_start) begin
      rd_en = 1'b1;
    end else if (state == E_HOLD && out_ready && !last) begin
      rd_en   = 1'b1;
      rd_addr = idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= E_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        E_IDLE: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
          if (burst_start) begin
            idx   <= '0;
            nregs <= fin.nregs;
            state <= E_LOAD;
          end else if (single) begin
            out_valid <= 1'b1;
            status    <= fin.status;
            reg_index <= 5'd0;
            reg_value <= fin.value;
            reg_count <= 6'd0;
            last      <= 1'b1;
          end
        end
        E_LOAD: begin
          out_valid <= 1'b1;
          status    <= mbrp_pkg::ST_OK;
          reg_index <= 5'(idx);
          reg_value <= rd_data;
          reg_count <= nregs[5:0];
          last      <= idx_last;
          state     <= E_HOLD;
        end
        E_HOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last) begin
              state <= E_IDLE;
            end else begin
              idx   <= rd_addr;
              state <= E_LOAD;
            end
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_write_in_burst: assert property (@(posedge clk) disable iff (rst)
    !(wr.en && state != E_IDLE))
    else $error("store written during a register burst");

  a_fin_output_free: assert property (@(posedge clk) disable iff (rst)
    (fin_valid && state == E_IDLE) |-> !out_valid)
    else $error("finish request arrived with the output register occupied");

  a_hold_has_item: assert property (@(posedge clk) disable iff (rst)
    (state == E_HOLD) |-> out_valid)
    else $error("burst holding state without a result shown");

  a_status_item_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != mbrp_pkg::ST_OK) |-> (last && reg_count == 6'd0))
    else $error("status item not marked last");

  a_load_follows_read: assert property (@(posedge clk) disable iff (rst)
    (state == E_LOAD) |-> $past(rd_en))
    else $error("result loaded without a store read");
`endif

endmodule

@@ rtl/core/modbus_rtu_response_parser.sv @@
// Top level of the Modbus RTU read-holding-registers response parser.
// Depends on mbrp_pkg, mbrp_cfg, mbrp_frame and mbrp_emit.
//
// Usage: the request channel (in_valid/in_ready, cmd, rx_byte) carries one
// command a request: cmd REQUEST opens a frame, BYTE feeds one received
// byte, TICK advances the timeout counter. The result channel
// (out_valid/out_ready) returns either one status item or, for a good
// function 3 reply, one item per 16-bit register with last on the final one.
// unit_id and timeout_ticks are set over the APB port (0x0, 0x4).
// Flow: a request is taken whenever in_ready is high. The cycle
// after a frame end is spent registering the finish decision. A status
// item passes through the finish register and then the result register; a
// register burst shows each item after a registered read of the register
// store, the next read starting when the previous item is taken.
// in_ready stays low until the burst's last item is taken.
// Reset clears the frame state, the sequencer state and out_valid; the store itself
// holds no reset and is read only at entries written in the same frame.
// A stalled receiver holds the current item and, while that item waits,
// the request channel.
module modbus_rtu_response_parser #(
  parameter int MAX_REGS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [4:0]  reg_index,
  output logic [15:0] reg_value,
  output logic [5:0]  reg_count,
  output logic        last
);

  logic [7:0]  unit_id;
  logic [15:0] timeout_ticks;
  logic        accept;
  logic        fin_valid;
  mbrp_pkg::fin_t fin;
  mbrp_pkg::wr_t  wr;

  assign accept = in_valid && in_ready;

  mbrp_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .unit_id       (unit_id),
    .timeout_ticks (timeout_ticks)
  );

  mbrp_frame #(
    .MAX_REGS (MAX_REGS)
  ) u_frame (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .cmd           (cmd),
    .rx_byte       (rx_byte),
    .unit_id       (unit_id),
    .timeout_ticks (timeout_ticks),
    .fin_valid     (fin_valid),
    .fin           (fin),
    .wr            (wr)
  );

  mbrp_emit #(
    .MAX_REGS (MAX_REGS)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .fin_valid (fin_valid),
    .fin       (fin),
    .take_ok   (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .reg_index (reg_index),
    .reg_value (reg_value),
    .reg_count (reg_count),
    .last      (last)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for modbus_rtu_response_parser: builds Modbus RTU replies (good,
// corrupted, truncated, wrong slave, exceptions, bad counts, timeouts) and checks each
// result item against an in-bench frame tracker. Depends on mbrp_pkg and the parser RTL.
module testbench;

  localparam int MAX_REGS = 32;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS = 100;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
  } rx_request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  index;
    logic [15:0] value;
    logic [5:0]  count;
    logic        last;
  } reply_item_t;

  typedef logic [7:0] byte_list_t[$];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = mbrp_pkg::CMD_REQUEST;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [4:0]  reg_index;
  logic [15:0] reg_value;
  logic [5:0]  reg_count;
  logic        last;

  modbus_rtu_response_parser #(.MAX_REGS(MAX_REGS)) uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .reg_index(reg_index), .reg_value(reg_value),
    .reg_count(reg_count), .last(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // frame tracker state
  logic [7:0]  cfg_slave;
  logic [15:0] cfg_timeout;
  logic        frame_open;
  logic [7:0]  rx_pos;
  logic [15:0] crc_acc;
  logic [7:0]  crc_low_rx;
  logic [7:0]  addr_rx;
  logic [7:0]  func_rx;
  logic [7:0]  count_rx;
  logic [7:0]  high_hold;
  logic [15:0] reg_mem [MAX_REGS];
  logic [15:0] tick_cnt;

  reply_item_t replies_due[$];
  rx_request_t request_fifo[$];

  int  send_idle_pct = 15;
  int  recv_idle_pct = 86;
  int  frame_items = 0;
  int  error_count = 0;
  int  accepted_count = 0;
  int  checked_count = 0;
  int  status_tally [8] = '{default: 0};
  logic req_taken = 1'b0;

  // bit-serial reflected CRC-16
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      r = (r[0] ^ b[i]) ? ((r >> 1) ^ mbrp_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  task automatic expect_item(input logic [2:0] st, input logic [4:0] idx,
                             input logic [15:0] val, input logic [5:0] cnt, input logic lst);
    reply_item_t it;
    it.status = st;
    it.index  = idx;
    it.value  = val;
    it.count  = cnt;
    it.last   = lst;
    replies_due.push_back(it);
  endtask

  task automatic close_with_status(input logic [2:0] st, input logic [15:0] val);
    frame_open = 1'b0;
    expect_item(st, '0, val, '0, 1'b1);
  endtask

  task automatic track_frame(input logic [1:0] c, input logic [7:0] b);
    int pos;
    int flen;
    int off;
    int nregs;
    case (c)
      mbrp_pkg::CMD_REQUEST: begin
        frame_open = 1'b1;
        rx_pos     = '0;
        crc_acc    = mbrp_pkg::CRC_INIT;
        crc_low_rx = '0;
        addr_rx    = '0;
        func_rx    = '0;
        count_rx   = '0;
        high_hold  = '0;
        tick_cnt   = '0;
      end
      mbrp_pkg::CMD_TICK: begin
        if (frame_open) begin
          if (tick_cnt != mbrp_pkg::TICK_MAX) tick_cnt = tick_cnt + 16'd1;
          if (tick_cnt >= cfg_timeout) close_with_status(mbrp_pkg::ST_TIMEOUT, '0);
        end
      end
      mbrp_pkg::CMD_BYTE: begin
        if (frame_open) begin
          pos = rx_pos;
          rx_pos = rx_pos + 8'd1;
          if (pos < 3) begin
            crc_acc = crc16_next(crc_acc, b);
            if (pos == 0) begin
              addr_rx = b;
            end else if (pos == 1) begin
              func_rx = b;
            end else begin
              count_rx = b;
              if (func_rx == mbrp_pkg::FUNC_READ && (b[0] || b > 2 * MAX_REGS))
                close_with_status(mbrp_pkg::ST_BAD_LENGTH, '0);
            end
          end else begin
            if (func_rx[mbrp_pkg::FUNC_EXC_BIT]) flen = mbrp_pkg::LEN_EXCEPTION;
            else if (func_rx == mbrp_pkg::FUNC_READ) flen = mbrp_pkg::LEN_READ_BASE + count_rx;
            else flen = mbrp_pkg::LEN_OTHER;
            if (pos + 2 < flen) begin
              off = pos - 3;
              crc_acc = crc16_next(crc_acc, b);
              if (func_rx == mbrp_pkg::FUNC_READ) begin
                if (off % 2 == 0) high_hold = b;
                else if (off / 2 < MAX_REGS) reg_mem[off / 2] = {high_hold, b};
              end
            end else if (pos + 2 == flen) begin
              crc_low_rx = b;
            end else if ({b, crc_low_rx} != crc_acc) begin
              close_with_status(mbrp_pkg::ST_CRC_ERR, '0);
            end else if (addr_rx != cfg_slave) begin
              close_with_status(mbrp_pkg::ST_WRONG_SLAVE, '0);
            end else if (func_rx[mbrp_pkg::FUNC_EXC_BIT]) begin
              close_with_status(mbrp_pkg::ST_EXCEPTION, {8'h00, count_rx});
            end else if (func_rx != mbrp_pkg::FUNC_READ) begin
              close_with_status(mbrp_pkg::ST_BAD_FUNC, '0);
            end else begin
              frame_open = 1'b0;
              nregs = count_rx / 2;
              if (nregs == 0) begin
                expect_item(mbrp_pkg::ST_OK, '0, '0, '0, 1'b1);
              end else begin
                for (int i = 0; i < nregs && i < MAX_REGS; i++) begin
                  expect_item(mbrp_pkg::ST_OK, 5'(i), reg_mem[i], 6'(nregs),
                              i == nregs - 1);
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // accept requests and results at the rising edge
  always @(posedge clk) begin
    reply_item_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        track_frame(cmd, rx_byte);
        accepted_count++;
      end
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $error("unexpected result: status %0d index %0d value 0x%0h", status, reg_index,
                 reg_value);
          error_count++;
        end else begin
          want = replies_due.pop_front();
          check_field("status", want.status, status);
          check_field("reg_index", want.index, reg_index);
          check_field("reg_value", want.value, reg_value);
          check_field("reg_count", want.count, reg_count);
          check_field("last", want.last, last);
          checked_count++;
          status_tally[status]++;
        end
      end
    end
  end

  // request driver and result back-pressure, both on the falling edge
  always @(negedge clk) begin
    rx_request_t nxt;
    if (!rst && !(in_valid && !req_taken)) begin
      if (request_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = request_fifo.pop_front();
        in_valid <= 1'b1;
        cmd      <= nxt.cmd;
        rx_byte  <= nxt.data;
      end else begin
        in_valid <= 1'b0;
        cmd      <= 2'($urandom);
        rx_byte  <= 8'($urandom);
      end
    end
    out_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic push_request(input logic [1:0] c, input logic [7:0] d);
    rx_request_t r;
    r.cmd  = c;
    r.data = d;
    request_fifo.push_back(r);
  endtask

  // append the CRC, optionally damage or truncate, and queue the frame with noise
  task automatic send_frame(input byte_list_t body, input logic [15:0] crc_flip, input int cut,
                            input int tick_pct);
    logic [15:0] crc;
    crc = mbrp_pkg::CRC_INIT;
    foreach (body[i]) crc = crc16_next(crc, body[i]);
    crc ^= crc_flip;
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    repeat (cut) void'(body.pop_back());
    push_request(mbrp_pkg::CMD_REQUEST, 8'($urandom));
    foreach (body[i]) begin
      if ($urandom_range(99) < tick_pct) push_request(mbrp_pkg::CMD_TICK, 8'($urandom));
      if ($urandom_range(49) == 0) push_request(CMD_UNUSED, 8'($urandom));
      push_request(mbrp_pkg::CMD_BYTE, body[i]);
    end
    frame_items += body.size() + 1;
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[2] == mbrp_pkg::REG_UNIT_ID) cfg_slave = data[7:0];
    else cfg_timeout = data[15:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] slave, input logic [15:0] ticks);
    apb_write({mbrp_pkg::REG_UNIT_ID, 2'b00}, {24'h0, slave});
    apb_write({mbrp_pkg::REG_TIMEOUT_TICKS, 2'b00}, {16'h0, ticks});
  endtask

  // hold until every request is taken and every result has arrived
  task automatic wait_drained();
    while (request_fifo.size() != 0 || in_valid || replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input logic [7:0] slave, input logic [15:0] ticks,
                            input int send_idle, input int recv_idle, input int tick_pct);
    byte_list_t  body;
    int          kind;
    int          nregs;
    int          cut;
    logic [7:0]  fn;
    logic [7:0]  cnt;
    logic [15:0] flip;
    wait_drained();
    set_config(slave, ticks);
    send_idle_pct = send_idle;
    recv_idle_pct = recv_idle;
    frame_items = 0;
    while (frame_items < PHASE_ITEMS) begin
      kind  = $urandom_range(99);
      fn    = mbrp_pkg::FUNC_READ;
      nregs = ($urandom_range(24) == 0) ? MAX_REGS : $urandom_range(6);
      cnt   = 8'(2 * nregs);
      flip  = '0;
      cut   = 0;
      if (kind < 6) begin
        cnt = $urandom_range(1) ? (8'($urandom) | 8'h01)
                                : 8'($urandom_range(255, 2 * MAX_REGS + 1));
      end else if (kind < 14) begin
        fn  = $urandom_range(1) ? 8'h83 : (8'h80 | 8'($urandom_range(127)));
        cnt = 8'($urandom);
      end else if (kind < 20) begin
        fn = 8'($urandom_range(127));
        if (fn == mbrp_pkg::FUNC_READ) fn = 8'h00;
        cnt = 8'($urandom);
      end else if (kind < 28) begin
        flip = 16'(1) << $urandom_range(15);
      end else if (kind < 33) begin
        cut = 1 + $urandom_range(2);
      end
      body = {};
      body.push_back((kind >= 33 && kind < 40) ? cfg_slave ^ 8'($urandom_range(255, 1))
                                               : cfg_slave);
      body.push_back(fn);
      body.push_back(cnt);
      if (fn == mbrp_pkg::FUNC_READ && !cnt[0] && cnt <= 2 * MAX_REGS) begin
        repeat (cnt) begin
          case ($urandom_range(7))
            0: body.push_back(8'h00);
            1: body.push_back(8'hFF);
            default: body.push_back(8'($urandom));
          endcase
        end
      end else if (!fn[mbrp_pkg::FUNC_EXC_BIT] && fn != mbrp_pkg::FUNC_READ) begin
        repeat (2) body.push_back(8'($urandom));
      end
      // stray traffic outside a frame
      if ($urandom_range(19) == 0) begin
        push_request(mbrp_pkg::CMD_BYTE, 8'($urandom));
        push_request(mbrp_pkg::CMD_TICK, 8'($urandom));
      end
      send_frame(body, flip, cut, tick_pct);
    end
  endtask

  initial begin
    byte_list_t body;
    cfg_slave   = mbrp_pkg::UNIT_ID_RESET;
    cfg_timeout = mbrp_pkg::TIMEOUT_RESET;
    frame_open  = 1'b0;
    rx_pos      = '0;
    crc_acc     = mbrp_pkg::CRC_INIT;
    crc_low_rx  = '0;
    addr_rx     = '0;
    func_rx     = '0;
    count_rx    = '0;
    high_hold   = '0;
    tick_cnt    = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: ignored traffic, full-scale registers, empty reply, oversized count, timeout
    set_config(8'h00, 16'd1);
    push_request(mbrp_pkg::CMD_BYTE, 8'hA5);
    push_request(mbrp_pkg::CMD_TICK, 8'h00);
    push_request(CMD_UNUSED, 8'hFF);
    body = {8'h00, mbrp_pkg::FUNC_READ, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h00};
    send_frame(body, '0, 0, 0);
    body = {8'h00, mbrp_pkg::FUNC_READ, 8'h00};
    send_frame(body, '0, 0, 0);
    body = {8'h00, mbrp_pkg::FUNC_READ, 8'h41};
    send_frame(body, '0, 2, 0);
    push_request(mbrp_pkg::CMD_REQUEST, 8'h00);
    push_request(mbrp_pkg::CMD_TICK, 8'h00);

    run_random(8'hFF, mbrp_pkg::TIMEOUT_RESET, 15, 86, 5);
    run_random(8'($urandom_range(254, 1)), 16'($urandom_range(12, 2)), 86, 15, 20);
    run_random(mbrp_pkg::UNIT_ID_RESET, 16'hFFFF, 0, 0, 10);
    run_random(8'($urandom), 16'd1, 0, 0, 2);
    wait_drained();

    $display("Covered %0d accepted requests and %0d checked result items over five phases",
             accepted_count, checked_count);
    $display("Status mix: ok %0d crc %0d slave %0d exception %0d function %0d",
             status_tally[mbrp_pkg::ST_OK], status_tally[mbrp_pkg::ST_CRC_ERR],
             status_tally[mbrp_pkg::ST_WRONG_SLAVE], status_tally[mbrp_pkg::ST_EXCEPTION],
             status_tally[mbrp_pkg::ST_BAD_FUNC]);
    $display("            timeout %0d length %0d",
             status_tally[mbrp_pkg::ST_TIMEOUT], status_tally[mbrp_pkg::ST_BAD_LENGTH]);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
